/* rtl/core/kmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared constants, codes and types of the k-means clustering block.
// ----------------------------------------------------------------------------
package kmc_pkg;

	localparam int MAX_POINTS   = 256;
	localparam int MAX_DIMS     = 8;
	localparam int MAX_CLUSTERS = 8;
	localparam int COORD_BITS   = 16;

	localparam int PIDX_W = $clog2(MAX_POINTS);
	localparam int DIDX_W = $clog2(MAX_DIMS);
	localparam int CIDX_W = $clog2(MAX_CLUSTERS);
	localparam int NPTS_W = PIDX_W + 1;
	localparam int NDIM_W = DIDX_W + 1;
	localparam int NCL_W  = CIDX_W + 1;
	localparam int PT_AW  = PIDX_W + DIDX_W;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int ACC_W  = SQ_W + DIDX_W;
	localparam int SUM_W  = COORD_BITS + PIDX_W;
	localparam int CNT_W  = NPTS_W;
	localparam int RND_W  = 8;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RUN    = 2'd1,
		OP_RD_ASG = 2'd2,
		OP_RD_CTR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_NUM_POINTS   = 3'd0,
		CFG_NUM_DIMS     = 3'd1,
		CFG_NUM_CLUSTERS = 3'd2,
		CFG_ROUNDS       = 3'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEED,
		S_SEED_WAIT,
		S_RND_START,
		S_ASG_RD,
		S_ASG_WAIT,
		S_WAVE,
		S_ACCUM,
		S_DIV_SEL,
		S_DIV_RUN
	} state_t;

	// Best-so-far distance handed from cell to cell.
	typedef struct packed {
		logic [ACC_W-1:0]  best_dist;
		logic [CIDX_W-1:0] pos;
	} kmc_carry_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                  clear;
		logic                  cw_en;
		logic [CIDX_W-1:0]     cw_idx;
		logic [DIDX_W-1:0]     cw_dim;
		logic [COORD_BITS-1:0] cw_val;
		logic                  x_vld;
		logic                  x_first;
		logic [DIDX_W-1:0]     x_dim;
		logic [COORD_BITS-1:0] x_val;
		logic                  wave_en;
		logic [CIDX_W-1:0]     wave_step;
		logic [NCL_W-1:0]      k_lim;
		logic                  acc_en;
		logic [CIDX_W-1:0]     acc_idx;
		logic                  shift_en;
		logic [CIDX_W-1:0]     shift_idx;
		logic [DIDX_W-1:0]     rd_dim;
	} kmc_ctl_t;

endpackage

/* rtl/core/kmc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/core/kmc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_div
// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kmc_pkg::SUM_W-1:0]  dividend,
	input  logic [kmc_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [kmc_pkg::SUM_W-1:0]  quot
);
	import kmc_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic              neg_q;
	logic [SUM_W-1:0]  q_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic              qbit;
	logic [CNT_W:0]    diff;

	assign trial = {rem_q, q_q[SUM_W-1]};
	assign qbit  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			q_q   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			q_q   <= {q_q[SUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? SUM_W'(-q_q) : q_q;
endmodule

/* rtl/core/kmc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_cell
// One cluster cell: center, distance accumulator, sums and member count.
// ----------------------------------------------------------------------------
module kmc_cell (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic [kmc_pkg::CIDX_W-1:0]                         cell_idx,
	input  kmc_pkg::kmc_ctl_t                                  ctl,
	input  logic [kmc_pkg::MAX_DIMS-1:0][kmc_pkg::COORD_BITS-1:0] pbuf,
	input  kmc_pkg::kmc_carry_t                                carry_in,
	output kmc_pkg::kmc_carry_t                                carry_out,
	output logic [kmc_pkg::CNT_W-1:0]                          count,
	output logic [kmc_pkg::SUM_W-1:0]                          sum_head,
	output logic [kmc_pkg::COORD_BITS-1:0]                     center_rd
);
	import kmc_pkg::*;

	logic [COORD_BITS-1:0] center_q [MAX_DIMS];
	logic [COORD_BITS-1:0] cref;
	logic signed [COORD_BITS:0] diff;
	logic [COORD_BITS-1:0] mag;
	logic [SQ_W-1:0]       sq_s1;
	logic                  vld_s1;
	logic                  first_s1;
	logic [ACC_W-1:0]      acc_q;
	kmc_carry_t            carry_q;
	logic [SUM_W-1:0]      sum_q [MAX_DIMS];
	logic [CNT_W-1:0]      count_q;
	logic                  take_own;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				center_q[d] <= '0;
			end
		end else if (ctl.cw_en && ctl.cw_idx == cell_idx) begin
			center_q[ctl.cw_dim] <= ctl.cw_val;
		end
	end

	// Squared difference is registered, then accumulated in the following cycle.
	assign cref = center_q[ctl.x_dim];
	assign diff = $signed({ctl.x_val[COORD_BITS-1], ctl.x_val})
		- $signed({cref[COORD_BITS-1], cref});
	assign mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.x_vld;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1    <= SQ_W'(mag) * SQ_W'(mag);
		first_s1 <= ctl.x_first;
		if (vld_s1) begin
			acc_q <= first_s1 ? ACC_W'(sq_s1) : acc_q + ACC_W'(sq_s1);
		end
	end

	// Strict compare keeps the lower index on a tie.
	assign take_own = (cell_idx == '0)
		|| ({1'b0, cell_idx} < ctl.k_lim && acc_q < carry_in.best_dist);

	always_ff @(posedge clk) begin
		if (ctl.wave_en && ctl.wave_step == cell_idx) begin
			carry_q <= take_own ? {acc_q, cell_idx} : carry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				sum_q[d] <= '0;
			end
		end else if (ctl.clear) begin
			count_q <= '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				sum_q[d] <= '0;
			end
		end else if (ctl.acc_en && ctl.acc_idx == cell_idx) begin
			count_q <= count_q + 1'b1;
			for (int d = 0; d < MAX_DIMS; d++) begin
				sum_q[d] <= sum_q[d]
					+ {{(SUM_W-COORD_BITS){pbuf[d][COORD_BITS-1]}}, pbuf[d]};
			end
		end else if (ctl.shift_en && ctl.shift_idx == cell_idx) begin
			for (int d = 0; d < MAX_DIMS - 1; d++) begin
				sum_q[d] <= sum_q[d+1];
			end
			sum_q[MAX_DIMS-1] <= '0;
		end
	end

	assign carry_out = carry_q;
	assign count     = count_q;
	assign sum_head  = sum_q[0];
	assign center_rd = center_q[ctl.rd_dim];
endmodule

/* rtl/core/kmeans_clustering.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering
// Lloyd k-means clustering over a point memory with a chain of cluster cells.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------------
// s_*      | s_tvalid / s_tready      | s_tdata: op, point_index, dim_index,
//          |                          | coord_value
// m_*      | m_tvalid / m_tready      | m_tdata: read_value, bad_index
// cfg_*    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Loads and reads are taken when the output register is free or emptying; the
// result sits there, and the next beat is taken in the cycle in which it leaves.
// A run is paced per point by the point memory port (one coordinate a cycle)
// and the argmin wave through the cell chain, and per center by the serial
// divider. Reset clears configuration to 1, centers and assignments to zero;
// no sweep. Input is refused while a run is in progress or a result beat is
// stalled, and configuration is refused while a run is in progress.
//
module kmeans_clustering (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [1:0] op, [9:2] point_index,
	                               // [12:10] dim_index, [28:13] coord_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] read_value, [16] bad_index
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kmc_pkg::*;

	// Configuration registers.
	logic [8:0] np_q;
	logic [3:0] nd_q;
	logic [3:0] nc_q;
	logic [RND_W-1:0] rounds_q;

	// Sequencer state, declared early because the configuration port uses it.
	state_t state_q, state_d;

	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q     <= 9'd1;
			nd_q     <= 4'd1;
			nc_q     <= 4'd1;
			rounds_q <= RND_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NUM_POINTS:   np_q     <= cfg_data[8:0];
				CFG_NUM_DIMS:     nd_q     <= cfg_data[3:0];
				CFG_NUM_CLUSTERS: nc_q     <= cfg_data[3:0];
				CFG_ROUNDS:       rounds_q <= cfg_data[RND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective counts, saturated into the supported ranges.
	logic [NPTS_W-1:0] n_eff;
	logic [NDIM_W-1:0] dims_eff;
	logic [NCL_W-1:0]  kc;
	logic [NCL_W-1:0]  k_eff;

	assign n_eff = (np_q == '0) ? NPTS_W'(1)
		: ((NPTS_W'(np_q) > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) : NPTS_W'(np_q));
	assign dims_eff = (nd_q == '0) ? NDIM_W'(1)
		: ((NDIM_W'(nd_q) > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : NDIM_W'(nd_q));
	assign kc = (nc_q == '0) ? NCL_W'(1)
		: ((NCL_W'(nc_q) > NCL_W'(MAX_CLUSTERS)) ? NCL_W'(MAX_CLUSTERS) : NCL_W'(nc_q));
	assign k_eff = (NPTS_W'(kc) > n_eff) ? NCL_W'(n_eff) : kc;

	// Input beat fields.
	op_t                   in_op;
	logic [PIDX_W-1:0]     in_pi;
	logic [DIDX_W-1:0]     in_di;
	logic [COORD_BITS-1:0] in_val;

	assign in_op  = op_t'(s_tdata[1:0]);
	assign in_pi  = s_tdata[9:2];
	assign in_di  = s_tdata[12:10];
	assign in_val = s_tdata[28:13];

	logic pi_ok, di_ok, ci_ok, s_fire, in_bad;

	assign pi_ok = NPTS_W'(in_pi) < n_eff;
	assign di_ok = NDIM_W'(in_di) < dims_eff;
	assign ci_ok = NPTS_W'(in_pi) < NPTS_W'(k_eff);

	always_comb begin
		in_bad = 1'b0;
		unique case (in_op)
			OP_LOAD:   in_bad = !(pi_ok && di_ok);
			OP_RUN:    in_bad = 1'b0;
			OP_RD_ASG: in_bad = !pi_ok;
			OP_RD_CTR: in_bad = !(ci_ok && di_ok);
			default:   in_bad = 1'b0;
		endcase
	end

	// Sequencer counters.
	logic [NPTS_W-1:0] p_q;
	logic [NDIM_W-1:0] d_q;
	logic [NCL_W-1:0]  c_q;
	logic [RND_W-1:0]  r_q;
	logic [CIDX_W-1:0] w_q;
	logic              wt_q;

	logic last_d, last_c, last_p, last_r, last_w;
	assign last_d = d_q == dims_eff - 1'b1;
	assign last_c = c_q == k_eff - 1'b1;
	assign last_p = p_q == n_eff - 1'b1;
	assign last_r = r_q == rounds_q - 1'b1;
	assign last_w = w_q == CIDX_W'(MAX_CLUSTERS - 1);

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign s_fire   = s_tvalid && s_tready;

	// Cell chain signals.
	kmc_ctl_t              ctl;
	kmc_carry_t            carry [MAX_CLUSTERS+1];
	logic [CNT_W-1:0]      cnt_c [MAX_CLUSTERS];
	logic [SUM_W-1:0]      sum_c [MAX_CLUSTERS];
	logic [COORD_BITS-1:0] ctr_c [MAX_CLUSTERS];
	logic [MAX_DIMS-1:0][COORD_BITS-1:0] pbuf_q;

	logic [CNT_W-1:0] cur_cnt;
	assign cur_cnt = cnt_c[c_q[CIDX_W-1:0]];

	logic div_start, div_done;
	logic [SUM_W-1:0] div_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire && in_op == OP_RUN) state_d = S_SEED;
			end
			S_SEED: begin
				if (last_d && last_c) state_d = S_SEED_WAIT;
			end
			S_SEED_WAIT: begin
				state_d = (rounds_q == '0) ? S_IDLE : S_RND_START;
			end
			S_RND_START: state_d = S_ASG_RD;
			S_ASG_RD: begin
				if (last_d) state_d = S_ASG_WAIT;
			end
			S_ASG_WAIT: begin
				if (wt_q) state_d = S_WAVE;
			end
			S_WAVE: begin
				if (last_w) state_d = S_ACCUM;
			end
			S_ACCUM: state_d = last_p ? S_DIV_SEL : S_ASG_RD;
			S_DIV_SEL: begin
				if (cur_cnt != '0) begin
					state_d = S_DIV_RUN;
				end else if (last_c) begin
					state_d = last_r ? S_IDLE : S_RND_START;
				end
			end
			S_DIV_RUN: begin
				if (div_done) begin
					if (!last_d || !last_c) begin
						state_d = S_DIV_SEL;
					end else begin
						state_d = last_r ? S_IDLE : S_RND_START;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Strobes.
	logic seed_rd, asg_rd, wave_en, acc_en, clear, div_wb;
	always_comb begin
		seed_rd   = 1'b0;
		asg_rd    = 1'b0;
		wave_en   = 1'b0;
		acc_en    = 1'b0;
		clear     = 1'b0;
		div_start = 1'b0;
		div_wb    = 1'b0;
		unique case (state_q)
			S_SEED:      seed_rd = 1'b1;
			S_RND_START: clear = 1'b1;
			S_ASG_RD:    asg_rd = 1'b1;
			S_WAVE:      wave_en = 1'b1;
			S_ACCUM:     acc_en = 1'b1;
			S_DIV_SEL:   div_start = cur_cnt != '0;
			S_DIV_RUN:   div_wb = div_done;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			d_q     <= '0;
			c_q     <= '0;
			r_q     <= '0;
			w_q     <= '0;
			wt_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					d_q <= '0;
					c_q <= '0;
					r_q <= '0;
				end
				S_SEED: begin
					d_q <= last_d ? '0 : d_q + 1'b1;
					if (last_d) c_q <= c_q + 1'b1;
				end
				S_RND_START: begin
					p_q <= '0;
					d_q <= '0;
				end
				S_ASG_RD: begin
					d_q  <= last_d ? '0 : d_q + 1'b1;
					wt_q <= 1'b0;
				end
				S_ASG_WAIT: begin
					wt_q <= 1'b1;
					w_q  <= '0;
				end
				S_WAVE: w_q <= w_q + 1'b1;
				S_ACCUM: begin
					p_q <= p_q + 1'b1;
					c_q <= '0;
					d_q <= '0;
				end
				S_DIV_SEL: begin
					if (cur_cnt == '0) begin
						c_q <= last_c ? '0 : c_q + 1'b1;
						if (last_c) r_q <= r_q + 1'b1;
					end
				end
				S_DIV_RUN: begin
					if (div_done) begin
						d_q <= last_d ? '0 : d_q + 1'b1;
						if (last_d) c_q <= last_c ? '0 : c_q + 1'b1;
						if (last_d && last_c) r_q <= r_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Point memory: loads write at beat time, runs read one coordinate a cycle.
	logic [PT_AW-1:0]      pt_addr;
	logic                  pt_we;
	logic [COORD_BITS-1:0] pt_rdata;

	always_comb begin
		if (state_q == S_SEED) begin
			pt_addr = {PIDX_W'(c_q), d_q[DIDX_W-1:0]};
		end else if (state_q == S_ASG_RD) begin
			pt_addr = {p_q[PIDX_W-1:0], d_q[DIDX_W-1:0]};
		end else begin
			pt_addr = {in_pi, in_di};
		end
	end
	assign pt_we = s_fire && in_op == OP_LOAD && !in_bad;

	kmc_ram #(
		.WIDTH (COORD_BITS),
		.DEPTH (MAX_POINTS * MAX_DIMS)
	) u_point_ram (
		.clk   (clk),
		.en    (1'b1),
		.we    (pt_we),
		.addr  (pt_addr),
		.wdata (in_val),
		.rdata (pt_rdata)
	);

	// Tags that travel with the registered memory read.
	logic              seed_vld_s1, x_vld_s1, x_first_s1;
	logic [CIDX_W-1:0] seed_c_s1;
	logic [DIDX_W-1:0] tag_d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_vld_s1 <= 1'b0;
			x_vld_s1    <= 1'b0;
		end else begin
			seed_vld_s1 <= seed_rd;
			x_vld_s1    <= asg_rd;
		end
	end

	always_ff @(posedge clk) begin
		seed_c_s1  <= c_q[CIDX_W-1:0];
		tag_d_s1   <= d_q[DIDX_W-1:0];
		x_first_s1 <= d_q == '0;
		if (x_vld_s1) pbuf_q[tag_d_s1] <= pt_rdata;
	end

	// Broadcast to the cells.
	always_comb begin
		ctl.clear     = clear;
		ctl.cw_en     = seed_vld_s1 || div_wb;
		ctl.cw_idx    = div_wb ? c_q[CIDX_W-1:0] : seed_c_s1;
		ctl.cw_dim    = div_wb ? d_q[DIDX_W-1:0] : tag_d_s1;
		ctl.cw_val    = div_wb ? div_q[COORD_BITS-1:0] : pt_rdata;
		ctl.x_vld     = x_vld_s1;
		ctl.x_first   = x_first_s1;
		ctl.x_dim     = tag_d_s1;
		ctl.x_val     = pt_rdata;
		ctl.wave_en   = wave_en;
		ctl.wave_step = w_q;
		ctl.k_lim     = k_eff;
		ctl.acc_en    = acc_en;
		ctl.acc_idx   = carry[MAX_CLUSTERS].pos;
		ctl.shift_en  = div_wb;
		ctl.shift_idx = c_q[CIDX_W-1:0];
		ctl.rd_dim    = in_di;
	end

	assign carry[0] = '0;

	for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
		kmc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (CIDX_W'(g)),
			.ctl       (ctl),
			.pbuf      (pbuf_q),
			.carry_in  (carry[g]),
			.carry_out (carry[g+1]),
			.count     (cnt_c[g]),
			.sum_head  (sum_c[g]),
			.center_rd (ctr_c[g])
		);
	end

	kmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_c[c_q[CIDX_W-1:0]]),
		.divisor  (cur_cnt),
		.done     (div_done),
		.quot     (div_q)
	);

	// Assignment memory; entries never written read as cluster zero.
	logic [MAX_POINTS-1:0] asg_vld_q;
	logic [PIDX_W-1:0]     asg_addr;
	logic                  asg_en;
	logic [CIDX_W-1:0]     asg_rdata;

	assign asg_addr = acc_en ? p_q[PIDX_W-1:0] : in_pi;
	assign asg_en   = acc_en || (s_fire && in_op == OP_RD_ASG);

	kmc_ram #(
		.WIDTH (CIDX_W),
		.DEPTH (MAX_POINTS)
	) u_asg_ram (
		.clk   (clk),
		.en    (asg_en),
		.we    (acc_en),
		.addr  (asg_addr),
		.wdata (carry[MAX_CLUSTERS].pos),
		.rdata (asg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asg_vld_q <= '0;
		end else if (acc_en) begin
			asg_vld_q[p_q[PIDX_W-1:0]] <= 1'b1;
		end
	end

	// Result register. A cluster read takes its value straight from the
	// memory's read register, which holds until the next access.
	logic                  out_vld_q, out_bad_q, out_asg_q, out_asgv_q;
	logic [COORD_BITS-1:0] out_val_q;
	logic [COORD_BITS-1:0] read_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s_fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_bad_q  <= in_bad;
			out_asg_q  <= in_op == OP_RD_ASG && !in_bad;
			out_asgv_q <= asg_vld_q[in_pi];
			out_val_q  <= (in_op == OP_RD_CTR && !in_bad)
				? ctr_c[in_pi[CIDX_W-1:0]] : '0;
		end
	end

	assign read_value = out_asg_q
		? (out_asgv_q ? COORD_BITS'(asg_rdata) : '0) : out_val_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_bad_q, read_value};
endmodule

/* rtl/core/kmc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks of the k-means clustering block.
// ----------------------------------------------------------------------------
module kmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	// A held result beat keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Every accepted input beat leaves a result beat behind it.
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

	// A rejected index never carries a value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
		else $error("bad index with nonzero value");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0)
		else $error("padding bits set");

	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");
endmodule

bind kmeans_clustering kmc_checker u_kmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
